// ===== rtl/erq_pkg.sv =====
// Shared types and constants of the elevator request scheduler.
`timescale 1ns / 1ps
package erq_pkg;

	localparam int FLOORS_DEF     = 16;
	localparam int COUNT_BITS_DEF = 4;
	localparam int FLOOR_BITS     = 4;
	localparam int CMD_BITS       = 2;

	localparam logic [CMD_BITS-1:0] CMD_CALL   = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_BUTTON = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_STEP   = 2'd2;

	typedef struct packed {
		logic [CMD_BITS-1:0]   cmd;
		logic [FLOOR_BITS-1:0] req_floor;
		logic                  call_up;
	} req_t;

	typedef struct packed {
		logic                  moved;
		logic [FLOOR_BITS-1:0] target_floor;
		logic [FLOOR_BITS-1:0] car_floor;
		logic                  heading_up;
		logic                  in_motion;
		logic                  dropped;
	} res_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ctl_t;

endpackage

// ===== rtl/erq_req_if.sv =====
// Request channel: valid, ready and one request item.
`timescale 1ns / 1ps
interface erq_req_if;
	logic                           valid;
	logic                           ready;
	logic [erq_pkg::CMD_BITS-1:0]   cmd;
	logic [erq_pkg::FLOOR_BITS-1:0] req_floor;
	logic                           call_up;

	modport source (output valid, output cmd, output req_floor, output call_up, input ready);
	modport sink (input valid, input cmd, input req_floor, input call_up, output ready);
endinterface

// ===== rtl/erq_res_if.sv =====
// Result channel: valid, ready and one result item.
`timescale 1ns / 1ps
interface erq_res_if;
	logic                           valid;
	logic                           ready;
	logic                           moved;
	logic [erq_pkg::FLOOR_BITS-1:0] target_floor;
	logic [erq_pkg::FLOOR_BITS-1:0] car_floor;
	logic                           heading_up;
	logic                           in_motion;
	logic                           dropped;

	modport source (output valid, output moved, output target_floor, output car_floor,
		output heading_up, output in_motion, output dropped, input ready);
	modport sink (input valid, input moved, input target_floor, input car_floor,
		input heading_up, input in_motion, input dropped, output ready);
endinterface

// ===== rtl/erq_ctrl.sv =====
// Controller: sequences item transfer, execution and result hand-off.
`timescale 1ns / 1ps
module erq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output erq_pkg::ctl_t ctl
);
	import erq_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign ctl.load  = in_valid && (state_q == ST_IDLE);
	assign ctl.exec  = (state_q == ST_EXEC) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_EXEC;
				ST_EXEC: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_exec_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |-> !(out_valid_q && !out_ready))
		else $error("execute while result still held");
	a_exec_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |=> out_valid_q)
		else $error("result not presented after execute");
	a_load_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.load && ctl.exec))
		else $error("load and execute together");
endmodule

// ===== rtl/erq_datapath.sv =====
// Datapath: pending counts, car state, priority encoders and result register.
`timescale 1ns / 1ps
module erq_datapath #(
	parameter int FLOORS     = erq_pkg::FLOORS_DEF,
	parameter int COUNT_BITS = erq_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  erq_pkg::ctl_t ctl,
	input  erq_pkg::req_t req_in,
	output erq_pkg::res_t res_out
);
	import erq_pkg::*;

	localparam int USED = (FLOORS < (1 << FLOOR_BITS)) ? FLOORS : (1 << FLOOR_BITS);
	localparam int IDXW = $clog2(USED);

	logic [COUNT_BITS-1:0] up_q   [USED];
	logic [COUNT_BITS-1:0] down_q [USED];
	logic [FLOOR_BITS-1:0] floor_q;
	logic                  going_up_q;
	logic                  busy_q;
	req_t                  item_q;
	res_t                  res_q;

	logic [USED-1:0] up_nz, dn_nz, up_full, dn_full;
	logic [IDXW-1:0] lo, hi, fl_idx;
	logic            lo_ok, hi_ok, fl_ok;
	logic            file_up, file_dn, pop_up, pop_dn;
	logic            going_d, busy_d, dropped_d;
	logic [FLOOR_BITS-1:0] floor_d, dest;

	assign fl_ok  = int'(item_q.req_floor) < USED;
	assign fl_idx = item_q.req_floor[IDXW-1:0];
	assign lo_ok  = |up_nz;
	assign hi_ok  = |dn_nz;

	always_comb begin
		lo = '0;
		hi = '0;
		for (int i = 0; i < USED; i++) begin
			up_nz[i]   = |up_q[i];
			dn_nz[i]   = |down_q[i];
			up_full[i] = &up_q[i];
			dn_full[i] = &down_q[i];
		end
		for (int i = USED - 1; i >= 0; i--) begin
			if (up_nz[i]) lo = IDXW'(i);
		end
		for (int i = 0; i < USED; i++) begin
			if (dn_nz[i]) hi = IDXW'(i);
		end
	end

	always_comb begin
		file_up = 1'b0;
		file_dn = 1'b0;
		pop_up  = 1'b0;
		pop_dn  = 1'b0;
		going_d = going_up_q;
		busy_d  = busy_q;
		case (item_q.cmd)
			CMD_CALL: begin
				if (fl_ok) begin
					file_up = item_q.call_up;
					file_dn = !item_q.call_up;
				end
			end
			CMD_BUTTON: begin
				if (fl_ok) begin
					if (!busy_q) begin
						if (floor_q < item_q.req_floor) begin
							file_up = 1'b1;
							going_d = 1'b1;
							busy_d  = 1'b1;
						end else if (floor_q > item_q.req_floor) begin
							file_dn = 1'b1;
							going_d = 1'b0;
							busy_d  = 1'b1;
						end
					end else if (going_up_q) begin
						file_up = item_q.req_floor > floor_q;
						file_dn = !(item_q.req_floor > floor_q);
					end else begin
						file_dn = item_q.req_floor < floor_q;
						file_up = !(item_q.req_floor < floor_q);
					end
				end
			end
			CMD_STEP: begin
				if (busy_q) begin
					if (going_up_q) begin
						if (lo_ok) pop_up = 1'b1;
						else if (hi_ok) going_d = 1'b0;
						else busy_d = 1'b0;
					end else begin
						if (hi_ok) pop_dn = 1'b1;
						else if (lo_ok) going_d = 1'b1;
						else busy_d = 1'b0;
					end
				end else begin
					if (lo_ok) pop_up = 1'b1;
					else if (hi_ok) pop_dn = 1'b1;
				end
			end
			default: ;
		endcase
		dest    = pop_up ? FLOOR_BITS'(lo) : FLOOR_BITS'(hi);
		floor_d = floor_q;
		if (pop_up || pop_dn) begin
			going_d = floor_q < dest;
			floor_d = dest;
		end
		dropped_d = (file_up && up_full[fl_idx]) || (file_dn && dn_full[fl_idx]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < USED; i++) begin
				up_q[i]   <= '0;
				down_q[i] <= '0;
			end
			floor_q    <= '0;
			going_up_q <= 1'b1;
			busy_q     <= 1'b0;
		end else if (ctl.exec) begin
			for (int i = 0; i < USED; i++) begin
				if (file_up && fl_idx == IDXW'(i) && !up_full[i])
					up_q[i] <= up_q[i] + 1'b1;
				else if (pop_up && lo == IDXW'(i))
					up_q[i] <= up_q[i] - 1'b1;
				if (file_dn && fl_idx == IDXW'(i) && !dn_full[i])
					down_q[i] <= down_q[i] + 1'b1;
				else if (pop_dn && hi == IDXW'(i))
					down_q[i] <= down_q[i] - 1'b1;
			end
			floor_q    <= floor_d;
			going_up_q <= going_d;
			busy_q     <= busy_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) item_q <= req_in;
		if (ctl.exec) begin
			res_q.moved        <= pop_up || pop_dn;
			res_q.target_floor <= (pop_up || pop_dn) ? dest : '0;
			res_q.car_floor    <= floor_d;
			res_q.heading_up   <= going_d;
			res_q.in_motion    <= busy_d;
			res_q.dropped      <= dropped_d;
		end
	end

	assign res_out = res_q;

	a_move_lands: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |=> (!res_q.moved || res_q.car_floor == res_q.target_floor))
		else $error("car floor differs from move target");
	a_step_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.exec && item_q.cmd == CMD_STEP) |=> !res_q.dropped)
		else $error("drop flagged on a control step");
	a_single_pop: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |-> !((pop_up || pop_dn) && (file_up || file_dn)) && !(pop_up && pop_dn))
		else $error("conflicting count updates");
endmodule

// ===== rtl/elevator_request_scheduler_top.sv =====
// A request transfer is captured in the item register; its execution registers the
// result once the output register is free. No request is taken during execution;
// a new request transfer is taken while the previous result waits in the output register.
// Execution holds while an untaken result blocks the output register.
// Reset clears all pending counts, puts the car on floor 0 heading up and idle.
// Top level of the elevator request scheduler.
`timescale 1ns / 1ps
module elevator_request_scheduler_top #(
	parameter int FLOORS     = erq_pkg::FLOORS_DEF,
	parameter int COUNT_BITS = erq_pkg::COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	erq_req_if.sink    req,
	erq_res_if.source  res
);
	import erq_pkg::*;

	ctl_t ctl;
	req_t req_item;
	res_t res_item;

	assign req_item.cmd       = req.cmd;
	assign req_item.req_floor = req.req_floor;
	assign req_item.call_up   = req.call_up;

	erq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.ctl       (ctl)
	);

	erq_datapath #(
		.FLOORS     (FLOORS),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.req_in  (req_item),
		.res_out (res_item)
	);

	assign res.moved        = res_item.moved;
	assign res.target_floor = res_item.target_floor;
	assign res.car_floor    = res_item.car_floor;
	assign res.heading_up   = res_item.heading_up;
	assign res.in_motion    = res_item.in_motion;
	assign res.dropped      = res_item.dropped;
endmodule

// ===== bench/tb_elevator_request_scheduler_top.sv =====
// Self-checking bench for the elevator request scheduler: directed and random traffic.
`timescale 1ns / 1ps
module tb_elevator_request_scheduler_top;
	import erq_pkg::*;

	localparam int FLOORS      = FLOORS_DEF;
	localparam int COUNT_BITS  = COUNT_BITS_DEF;
	localparam int COUNT_TOP   = (1 << COUNT_BITS) - 1;
	localparam int ITEMS       = 1350;
	localparam int CALM_FROM   = 1200;
	localparam int HOLD_AT     = 500;
	localparam int HOLD_CYCLES = 300;
	localparam int LIMIT       = 400000;

	localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

	class dispatch_scoreboard;
		int unsigned up_cnt[FLOORS];
		int unsigned dn_cnt[FLOORS];
		logic [FLOOR_BITS-1:0] car;
		logic heading;
		logic busy;
		res_t awaited_status[$];
		int errors;
		int requests;
		int statuses;
		int moves;
		int drops;
		int reversals;

		function new();
			foreach (up_cnt[i]) begin
				up_cnt[i] = 0;
				dn_cnt[i] = 0;
			end
			car = '0;
			heading = 1'b1;
			busy = 1'b0;
			errors = 0;
			requests = 0;
			statuses = 0;
			moves = 0;
			drops = 0;
			reversals = 0;
		endfunction

		task report(input string what, input int got, input int want);
			errors++;
			if (errors <= 40)
				$display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
		endtask

		function bit file_floor(input bit into_up, input int f);
			if (f >= FLOORS)
				return 1'b0;
			if (into_up) begin
				if (up_cnt[f] >= COUNT_TOP)
					return 1'b1;
				up_cnt[f]++;
			end else begin
				if (dn_cnt[f] >= COUNT_TOP)
					return 1'b1;
				dn_cnt[f]++;
			end
			return 1'b0;
		endfunction

		function logic [FLOOR_BITS-1:0] travel(input bit from_up, input int f);
			if (from_up)
				up_cnt[f]--;
			else
				dn_cnt[f]--;
			heading = (car < f);
			car = f[FLOOR_BITS-1:0];
			return f[FLOOR_BITS-1:0];
		endfunction

		function void note_request(input req_t r);
			int lo;
			int hi;
			int f;
			res_t want;
			want = '0;
			f = int'(r.req_floor);
			requests++;
			case (r.cmd)
				CMD_CALL: want.dropped = file_floor(r.call_up, f);
				CMD_BUTTON: begin
					if (f < FLOORS) begin
						if (!busy) begin
							if (car < f) begin
								want.dropped = file_floor(1'b1, f);
								heading = 1'b1;
								busy = 1'b1;
							end else if (car > f) begin
								want.dropped = file_floor(1'b0, f);
								heading = 1'b0;
								busy = 1'b1;
							end
						end else if (heading)
							want.dropped = file_floor(f > car, f);
						else
							want.dropped = file_floor(!(f < car), f);
					end
				end
				CMD_STEP: begin
					lo = -1;
					hi = -1;
					for (int i = FLOORS - 1; i >= 0; i--)
						if (up_cnt[i] != 0)
							lo = i;
					for (int i = 0; i < FLOORS; i++)
						if (dn_cnt[i] != 0)
							hi = i;
					if (busy && heading) begin
						if (lo >= 0) begin
							want.target_floor = travel(1'b1, lo);
							want.moved = 1'b1;
						end else if (hi >= 0) begin
							heading = 1'b0;
							reversals++;
						end else
							busy = 1'b0;
					end else if (busy) begin
						if (hi >= 0) begin
							want.target_floor = travel(1'b0, hi);
							want.moved = 1'b1;
						end else if (lo >= 0) begin
							heading = 1'b1;
							reversals++;
						end else
							busy = 1'b0;
					end else if (lo >= 0) begin
						want.target_floor = travel(1'b1, lo);
						want.moved = 1'b1;
					end else if (hi >= 0) begin
						want.target_floor = travel(1'b0, hi);
						want.moved = 1'b1;
					end
				end
				default: ;
			endcase
			want.car_floor = car;
			want.heading_up = heading;
			want.in_motion = busy;
			moves += want.moved;
			drops += want.dropped;
			awaited_status = {awaited_status, want};
		endfunction

		task check_status(input res_t got);
			res_t want;
			statuses++;
			if (awaited_status.size() == 0) begin
				report("result with none awaited", 1, 0);
			end else begin
				want = awaited_status.pop_front();
				if (got.moved !== want.moved)
					report("moved", got.moved, want.moved);
				if (got.target_floor !== want.target_floor)
					report("target_floor", got.target_floor, want.target_floor);
				if (got.car_floor !== want.car_floor)
					report("car_floor", got.car_floor, want.car_floor);
				if (got.heading_up !== want.heading_up)
					report("heading_up", got.heading_up, want.heading_up);
				if (got.in_motion !== want.in_motion)
					report("in_motion", got.in_motion, want.in_motion);
				if (got.dropped !== want.dropped)
					report("dropped", got.dropped, want.dropped);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	int cycles;
	bit calm;
	bit hold_asked;
	dispatch_scoreboard board;

	erq_req_if req_ch();
	erq_res_if res_ch();

	elevator_request_scheduler_top #(
		.FLOORS(FLOORS),
		.COUNT_BITS(COUNT_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		board = new();
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				board.note_request('{cmd: req_ch.cmd, req_floor: req_ch.req_floor,
					call_up: req_ch.call_up});
			if (res_ch.valid && res_ch.ready)
				board.check_status('{moved: res_ch.moved, target_floor: res_ch.target_floor,
					car_floor: res_ch.car_floor, heading_up: res_ch.heading_up,
					in_motion: res_ch.in_motion, dropped: res_ch.dropped});
		end
	end

	// result side: random stalls, one long hold-off, none once calm
	initial begin
		bit held;
		held = 1'b0;
		res_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_asked && !held) begin
				held = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			if (!calm && $urandom_range(0, 2) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	task automatic offer(input logic [CMD_BITS-1:0] c, input int f, input logic up);
		req_ch.valid <= 1'b1;
		req_ch.cmd <= c;
		req_ch.req_floor <= f[FLOOR_BITS-1:0];
		req_ch.call_up <= up;
		@(posedge clk);
		while (!(req_ch.valid && req_ch.ready))
			@(posedge clk);
	endtask

	task automatic pause(input int n);
		req_ch.valid <= 1'b0;
		req_ch.cmd <= CMD_BITS'($urandom_range(0, 3));
		req_ch.req_floor <= FLOOR_BITS'($urandom_range(0, FLOORS - 1));
		req_ch.call_up <= 1'($urandom_range(0, 1));
		repeat (n) @(posedge clk);
	endtask

	task automatic random_traffic(input int count);
		int sent;
		int mode;
		int chunk;
		int hot;
		int roll;
		int f;
		bit quiet;
		logic [CMD_BITS-1:0] c;
		sent = 0;
		while (sent < count) begin
			mode = $urandom_range(0, 2);
			chunk = $urandom_range(20, 60);
			hot = $urandom_range(0, FLOORS - 1);
			quiet = ($urandom_range(0, 4) == 0);
			for (int k = 0; k < chunk && sent < count; k++) begin
				roll = $urandom_range(0, 99);
				case (mode)
					0: c = (roll < 5) ? CMD_STEP : (roll < 60) ? CMD_CALL :
						(roll < 97) ? CMD_BUTTON : CMD_UNUSED;
					1: c = (roll < 35) ? CMD_STEP : (roll < 65) ? CMD_CALL :
						(roll < 95) ? CMD_BUTTON : CMD_UNUSED;
					default: c = (roll < 80) ? CMD_STEP : (roll < 88) ? CMD_CALL :
						(roll < 97) ? CMD_BUTTON : CMD_UNUSED;
				endcase
				f = (mode == 0 || $urandom_range(0, 2) == 0) ? hot :
					$urandom_range(0, FLOORS - 1);
				offer(c, f, 1'($urandom_range(0, 1)));
				sent++;
				if (board.requests >= HOLD_AT)
					hold_asked = 1'b1;
				if (board.requests >= CALM_FROM)
					calm = 1'b1;
				if (!calm && !quiet && $urandom_range(0, 3) == 0)
					pause($urandom_range(1, 16));
			end
		end
	endtask

	initial begin
		calm = 1'b0;
		hold_asked = 1'b0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= CMD_CALL;
		req_ch.req_floor <= '0;
		req_ch.call_up <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(CMD_BUTTON, 0, 1'b0);
		offer(CMD_STEP, 0, 1'b0);
		offer(CMD_UNUSED, 15, 1'b1);
		repeat (COUNT_TOP + 1) offer(CMD_CALL, 5, 1'b1);
		offer(CMD_BUTTON, 5, 1'b0);
		offer(CMD_BUTTON, 0, 1'b1);
		offer(CMD_STEP, 15, 1'b1);
		offer(CMD_STEP, 0, 1'b0);
		offer(CMD_BUTTON, 5, 1'b0);
		offer(CMD_CALL, 9, 1'b0);
		offer(CMD_STEP, 0, 1'b1);
		offer(CMD_CALL, 15, 1'b0);
		offer(CMD_CALL, 0, 1'b1);

		random_traffic(ITEMS - board.requests);
		pause(1);

		while (board.awaited_status.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d requests, %0d statuses checked; %0d moves, %0d reversals, %0d drops",
			board.requests, board.statuses, board.moves, board.reversals, board.drops);
		$display("traffic mixed calls, buttons, steps and unused commands with stalls");
		if (board.errors == 0 && board.awaited_status.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/erq_pkg.sv
rtl/erq_req_if.sv
rtl/erq_res_if.sv
rtl/erq_ctrl.sv
rtl/erq_datapath.sv
rtl/elevator_request_scheduler_top.sv
bench/tb_elevator_request_scheduler_top.sv
